// ----- hw/rtl/hdh_pkg.sv -----
package hdh_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int SQRT_STEPS   = 32;
  localparam int SQ_W         = $clog2(SQRT_STEPS);
  localparam int CW           = 34;

  typedef logic signed [CW-1:0] cval_t;

  localparam logic [31:0] RAD_PER_UNIT  = 32'd2012227627;
  localparam logic [31:0] TWO_RADIUS_CM = 32'd1274200000;
  localparam cval_t       CORDIC_GAIN   = 34'sd652032874;
  localparam cval_t       UNITS_QUARTER = 34'sd900000000;
  localparam cval_t       UNITS_HALF    = 34'sd1800000000;
  localparam cval_t       UNITS_FULL    = 34'sd3600000000;
  localparam logic [30:0] Q_ONE         = 31'h4000_0000;
  localparam logic [30:0] DIST_MAX      = 31'd2100000000;

  localparam logic [1:0] REG_HOME_LAT = 2'd0;
  localparam logic [1:0] REG_HOME_LON = 2'd1;
  localparam logic [1:0] REG_HOME_ALT = 2'd2;

  typedef struct packed {
    logic start;
    logic vec;
  } cor_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD,
    S_M_SLAT, S_C_SLAT, S_W_SLAT,
    S_M_SLON, S_C_SLON, S_W_SLON,
    S_M_CLAT, S_C_CLAT, S_W_CLAT,
    S_M_CHOM, S_C_CHOM, S_W_CHOM,
    S_M_H1, S_M_H2, S_M_CC, S_M_T, S_SUM_A,
    S_Q1, S_WQ1, S_Q2, S_WQ2, S_VEC, S_WVEC,
    S_M_GND, S_GND, S_M_GSQ, S_M_ADSQ, S_NSUM, S_WR, S_OUT
  } state_t;

  // round(atan(2^-i) * 2^30)
  function automatic cval_t atan_q30(input logic [STEP_W-1:0] i);
    cval_t v;
    logic [5:0] sh;
    sh = 6'd30 - 6'(i);
    case (i)
      STEP_W'(0): v = 34'sd843314857;
      STEP_W'(1): v = 34'sd497837829;
      STEP_W'(2): v = 34'sd263043837;
      STEP_W'(3): v = 34'sd133525159;
      STEP_W'(4): v = 34'sd67021687;
      STEP_W'(5): v = 34'sd33543516;
      STEP_W'(6): v = 34'sd16775851;
      STEP_W'(7): v = 34'sd8388437;
      STEP_W'(8): v = 34'sd4194283;
      STEP_W'(9): v = 34'sd2097149;
      default: begin
        if (int'(i) <= 30) v = cval_t'(34'd1 << sh);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/hdh_cordic.sv -----
module hdh_cordic (
  input  logic             clk,
  input  logic             rst_n,
  input  hdh_pkg::cor_cmd_t cmd,
  input  hdh_pkg::cval_t   x0,
  input  hdh_pkg::cval_t   y0,
  input  hdh_pkg::cval_t   z0,
  output logic             done,
  output hdh_pkg::cval_t   x,
  output hdh_pkg::cval_t   y,
  output hdh_pkg::cval_t   z
);
  import hdh_pkg::*;

  cval_t             x_r, y_r, z_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r, vec_r;

  cval_t dx, dy, at;
  logic  pos, up;

  always_comb begin
    dx  = y_r >>> cnt_r;
    dy  = x_r >>> cnt_r;
    at  = atan_q30(cnt_r);
    // rotation steers on z, vectoring on y
    pos = vec_r ? ~y_r[CW-1] : ~z_r[CW-1];
    up  = vec_r ^ pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      vec_r <= cmd.vec;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (up) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

// ----- hw/rtl/hdh_isqrt.sv -----
module hdh_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] n_in,
  output logic        done,
  output logic [32:0] root,
  output logic [63:0] rem
);
  import hdh_pkg::*;

  logic [63:0]     n_r, r_r, bit_r;
  logic [SQ_W-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [63:0]     trial;
  logic            ge;

  assign trial = r_r + bit_r;
  assign ge    = n_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == SQ_W'(SQRT_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= n_in;
      r_r   <= '0;
      bit_r <= 64'd1 << 62;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        n_r <= n_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign root = r_r[32:0];
  assign rem  = n_r;

endmodule

// ----- hw/rtl/haversine_distance_to_home.sv -----
// Distance to home: each transfer on the input carries one GPS fix. With
// fix_valid set, the block computes the haversine great-circle distance to
// the home point on a 6371 km sphere, combines it with the altitude
// difference and returns the straight-line distance in centimeters,
// saturated at 2100000000; without a fix it returns the last distance
// (zero after reset). One shared CORDIC unit (one iteration per cycle, 32
// iterations) serves four sine/cosine evaluations and one arctangent, one
// digit-by-digit square-root unit (32 steps) serves three roots, and one
// registered 32x32 multiplier serves every product. The input is not ready
// while a transfer is being worked on. A finished result waits in the output
// register while the next fix is taken. Home registers are to be written by the
// user through the cfg port only while the block is idle; the block itself
// does not enforce this.
module haversine_distance_to_home (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // latitude[30:0], longitude[62:31], altitude[87:63]
  input  logic [0:0]  in_tuser,   // fix_valid[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // distance_cm[30:0], zero[31]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import hdh_pkg::*;

  state_t state_r, state_nxt;

  logic signed [30:0] home_lat_r;
  logic signed [31:0] home_lon_r;
  logic signed [24:0] home_alt_r;

  logic signed [30:0] lat_r;
  logic signed [31:0] lon_r;
  logic signed [24:0] alt_r;

  cval_t       dlat_r, dlon_r, mlat_r, mhome_r;
  logic        nlat_r, nhome_r;
  logic [25:0] ad_r;
  cval_t       s1_r, s2_r, c1_r, c2_r, qx_r, qy_r;
  logic [31:0] h1_r, h2_r, ang_r;
  logic [30:0] a_r, ground_r, held_r, out_dist_r;
  logic [63:0] mul_r, gsq_r;
  logic        out_valid_r;

  logic [31:0] mul_a, mul_b;
  cor_cmd_t    cor_cmd;
  cval_t       cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;
  logic        cor_done;
  logic        sq_start, sq_done;
  logic [63:0] sq_n, sq_rem;
  logic [32:0] sq_root;

  logic        in_xfer;
  cval_t       d_lat, d_lon, m_lat, m_home, d_alt;
  logic        n_lat, n_home;
  logic signed [34:0] a_sum;
  logic [63:0] g_sum;
  logic [33:0] g_val, r_round;

  function automatic cval_t wrap_half(input cval_t d);
    cval_t w;
    w = d;
    if (d > UNITS_HALF) w = d - UNITS_FULL;
    else if (d < -UNITS_HALF) w = d + UNITS_FULL;
    return w;
  endfunction

  function automatic cval_t absv(input cval_t v);
    return v[CW-1] ? -v : v;
  endfunction

  function automatic logic [31:0] mag32(input cval_t v);
    cval_t m;
    m = absv(v);
    return m[31:0];
  endfunction

  assign in_xfer = in_tvalid && in_tready;

  // angle folding and differences
  always_comb begin
    d_lat  = wrap_half(cval_t'(home_lat_r) - cval_t'(lat_r));
    d_lon  = wrap_half(cval_t'(home_lon_r) - cval_t'(lon_r));
    d_alt  = absv(cval_t'(alt_r) - cval_t'(home_alt_r));
    m_lat  = absv(cval_t'(lat_r));
    n_lat  = m_lat > UNITS_QUARTER;
    if (n_lat) m_lat = UNITS_HALF - m_lat;
    m_home = absv(cval_t'(home_lat_r));
    n_home = m_home > UNITS_QUARTER;
    if (n_home) m_home = UNITS_HALF - m_home;
  end

  always_comb begin
    if (c1_r[CW-1] ^ c2_r[CW-1]) a_sum = 35'(h1_r) - 35'(mul_r[61:30]);
    else a_sum = 35'(h1_r) + 35'(mul_r[61:30]);
    g_sum   = mul_r + (64'd1 << 29);
    g_val   = g_sum[63:30];
    r_round = 34'(sq_root) + 34'(sq_rem > 64'(sq_root));
  end

  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    cor_cmd   = '0;
    cor_x0    = CORDIC_GAIN;
    cor_y0    = '0;
    cor_z0    = '0;
    sq_start  = 1'b0;
    sq_n      = gsq_r + mul_r;
    unique case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = in_tuser[0] ? S_LOAD : S_OUT;
      S_LOAD:   state_nxt = S_M_SLAT;
      S_M_SLAT: begin
        mul_a = mag32(dlat_r); mul_b = RAD_PER_UNIT; state_nxt = S_C_SLAT;
      end
      S_C_SLAT: begin
        cor_cmd.start = 1'b1;
        cor_z0 = dlat_r[CW-1] ? -cval_t'(mul_r[63:31]) : cval_t'(mul_r[63:31]);
        state_nxt = S_W_SLAT;
      end
      S_W_SLAT: if (cor_done) state_nxt = S_M_SLON;
      S_M_SLON: begin
        mul_a = mag32(dlon_r); mul_b = RAD_PER_UNIT; state_nxt = S_C_SLON;
      end
      S_C_SLON: begin
        cor_cmd.start = 1'b1;
        cor_z0 = dlon_r[CW-1] ? -cval_t'(mul_r[63:31]) : cval_t'(mul_r[63:31]);
        state_nxt = S_W_SLON;
      end
      S_W_SLON: if (cor_done) state_nxt = S_M_CLAT;
      S_M_CLAT: begin
        mul_a = mlat_r[31:0]; mul_b = RAD_PER_UNIT; state_nxt = S_C_CLAT;
      end
      S_C_CLAT: begin
        cor_cmd.start = 1'b1;
        cor_z0 = cval_t'(mul_r[63:30]);
        state_nxt = S_W_CLAT;
      end
      S_W_CLAT: if (cor_done) state_nxt = S_M_CHOM;
      S_M_CHOM: begin
        mul_a = mhome_r[31:0]; mul_b = RAD_PER_UNIT; state_nxt = S_C_CHOM;
      end
      S_C_CHOM: begin
        cor_cmd.start = 1'b1;
        cor_z0 = cval_t'(mul_r[63:30]);
        state_nxt = S_W_CHOM;
      end
      S_W_CHOM: if (cor_done) state_nxt = S_M_H1;
      S_M_H1: begin
        mul_a = mag32(s1_r); mul_b = mag32(s1_r); state_nxt = S_M_H2;
      end
      S_M_H2: begin
        mul_a = mag32(s2_r); mul_b = mag32(s2_r); state_nxt = S_M_CC;
      end
      S_M_CC: begin
        mul_a = mag32(c1_r); mul_b = mag32(c2_r); state_nxt = S_M_T;
      end
      S_M_T: begin
        mul_a = mul_r[61:30]; mul_b = h2_r; state_nxt = S_SUM_A;
      end
      S_SUM_A:  state_nxt = S_Q1;
      S_Q1: begin
        sq_start = 1'b1; sq_n = 64'(Q_ONE - a_r) << 30; state_nxt = S_WQ1;
      end
      S_WQ1:    if (sq_done) state_nxt = S_Q2;
      S_Q2: begin
        sq_start = 1'b1; sq_n = 64'(a_r) << 30; state_nxt = S_WQ2;
      end
      S_WQ2:    if (sq_done) state_nxt = S_VEC;
      S_VEC: begin
        cor_cmd.start = 1'b1; cor_cmd.vec = 1'b1;
        cor_x0 = qx_r; cor_y0 = qy_r;
        state_nxt = S_WVEC;
      end
      S_WVEC:   if (cor_done) state_nxt = S_M_GND;
      S_M_GND: begin
        mul_a = ang_r; mul_b = TWO_RADIUS_CM; state_nxt = S_GND;
      end
      S_GND:    state_nxt = S_M_GSQ;
      S_M_GSQ: begin
        mul_a = 32'(ground_r); mul_b = 32'(ground_r); state_nxt = S_M_ADSQ;
      end
      S_M_ADSQ: begin
        mul_a = 32'(ad_r); mul_b = 32'(ad_r); state_nxt = S_NSUM;
      end
      S_NSUM: begin
        sq_start = 1'b1; state_nxt = S_WR;
      end
      S_WR:     if (sq_done) state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_lat_r <= '0;
      home_lon_r <= '0;
      home_alt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOME_LAT: home_lat_r <= cfg_data[30:0];
        REG_HOME_LON: home_lon_r <= cfg_data;
        REG_HOME_ALT: home_alt_r <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_WR && sq_done)
        held_r <= (r_round > 34'(DIST_MAX)) ? DIST_MAX : r_round[30:0];
      // hold the result until the sink takes it
      if (state_r == S_OUT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (in_xfer) begin
      lat_r <= in_tdata[30:0];
      lon_r <= in_tdata[62:31];
      alt_r <= in_tdata[87:63];
    end
    if (state_r == S_OUT && (!out_valid_r || out_tready)) out_dist_r <= held_r;
    unique case (state_r)
      S_LOAD: begin
        dlat_r  <= d_lat;
        dlon_r  <= d_lon;
        mlat_r  <= m_lat;
        nlat_r  <= n_lat;
        mhome_r <= m_home;
        nhome_r <= n_home;
        ad_r    <= d_alt[25:0];
      end
      S_W_SLAT: if (cor_done) s1_r <= cor_y;
      S_W_SLON: if (cor_done) s2_r <= cor_y;
      S_W_CLAT: if (cor_done) c1_r <= nlat_r ? -cor_x : cor_x;
      S_W_CHOM: if (cor_done) c2_r <= nhome_r ? -cor_x : cor_x;
      S_M_H2:   h1_r <= mul_r[61:30];
      S_M_CC:   h2_r <= mul_r[61:30];
      S_SUM_A: begin
        // clamp rounding spill outside [0, 1]
        if (a_sum < 0) a_r <= '0;
        else if (a_sum > 35'(Q_ONE)) a_r <= Q_ONE;
        else a_r <= a_sum[30:0];
      end
      S_WQ1:    if (sq_done) qx_r <= cval_t'(sq_root);
      S_WQ2:    if (sq_done) qy_r <= cval_t'(sq_root);
      S_WVEC:   if (cor_done) ang_r <= cor_z[CW-1] ? '0 : cor_z[31:0];
      S_GND:    ground_r <= (g_val > 34'(DIST_MAX)) ? DIST_MAX : g_val[30:0];
      S_M_ADSQ: gsq_r <= mul_r;
      default: ;
    endcase
  end

  hdh_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cor_cmd),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .z0    (cor_z0),
    .done  (cor_done),
    .x     (cor_x),
    .y     (cor_y),
    .z     (cor_z)
  );

  hdh_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .n_in  (sq_n),
    .done  (sq_done),
    .root  (sq_root),
    .rem   (sq_rem)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_dist_r};

`ifndef SYNTHESIS
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input ready right after a transfer");

  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WR) |=> $stable(held_r))
    else $error("held distance changed outside the final root step");

  a_out_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dist_r <= DIST_MAX))
    else $error("result above saturation limit");
`endif

endmodule

// ----- tb/hdh_distance_checker.sv -----
`timescale 1ns / 1ps

module hdh_distance_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import hdh_pkg::*;

  localparam longint unsigned RAD_UNIT   = 64'd2012227627;
  localparam longint          GAIN_Q30   = 64'sd652032874;
  localparam longint          HALF_TURN  = 64'sd1800000000;
  localparam longint          FULL_TURN  = 64'sd3600000000;
  localparam longint          QUARTER    = 64'sd900000000;
  localparam longint          ONE_Q30    = 64'sd1073741824;
  localparam longint unsigned RADIUS_CM  = 64'd637100000;
  localparam longint unsigned LIMIT_CM   = 64'd2100000000;

  longint home_lat, home_lon, home_alt;
  logic [30:0] held_cm;
  logic [30:0] dist_q[$];

  assign pending = dist_q.size();

  function automatic longint atan_step(int i);
    longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint units_to_rad(longint u, int sh);
    longint r;
    r = longint'((abs64(u) * RAD_UNIT) >> sh);
    return u < 0 ? -r : r;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void rotate(input longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint half_sine(longint d);
    longint c, s;
    // wrap by a full turn into [-180, 180] degrees
    if (d > HALF_TURN) d -= FULL_TURN;
    if (d < -HALF_TURN) d += FULL_TURN;
    rotate(units_to_rad(d, 31), c, s);
    return s;
  endfunction

  function automatic longint lat_cosine(longint lat);
    longint m, c, s;
    bit flip;
    m = abs64(lat);
    flip = 0;
    if (m > QUARTER) begin
      m = HALF_TURN - m;
      flip = 1;
    end
    rotate(units_to_rad(m, 30), c, s);
    return flip ? -c : c;
  endfunction

  function automatic logic [30:0] distance_to_home(longint lat, longint lon, longint alt);
    longint s1, s2, c1, c2, t, a, ang;
    longint unsigned h1, h2, ground, ad, n, r;
    s1 = half_sine(home_lat - lat);
    s2 = half_sine(home_lon - lon);
    c1 = lat_cosine(lat);
    c2 = lat_cosine(home_lat);
    h1 = mul_q30(abs64(s1), abs64(s1));
    h2 = mul_q30(abs64(s2), abs64(s2));
    t = longint'(mul_q30(h2, mul_q30(abs64(c1), abs64(c2))));
    a = longint'(h1) + (((c1 < 0) != (c2 < 0)) ? -t : t);
    if (a < 0) a = 0;
    if (a > ONE_Q30) a = ONE_Q30;
    ang = vector_angle(longint'(root_floor(longint'(ONE_Q30 - a) << 30)),
                       longint'(root_floor(a << 30)));
    if (ang < 0) ang = 0;
    ground = (longint'(ang) * 64'd2 * RADIUS_CM + (64'd1 << 29)) >> 30;
    if (ground > LIMIT_CM) ground = LIMIT_CM;
    ad = abs64(alt - home_alt);
    n = ground * ground + ad * ad;
    r = root_floor(n);
    // round the final root to nearest
    if (n - r * r > r) r++;
    if (r > LIMIT_CM) r = LIMIT_CM;
    return r[30:0];
  endfunction

  always @(posedge clk) begin
    logic [30:0] want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      home_lat <= 0;
      home_lon <= 0;
      home_alt <= 0;
      held_cm = '0;
      dist_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HOME_LAT: home_lat <= longint'($signed(cfg_data[30:0]));
          REG_HOME_LON: home_lon <= longint'($signed(cfg_data[31:0]));
          REG_HOME_ALT: home_alt <= longint'($signed(cfg_data[24:0]));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0])
          held_cm = distance_to_home(longint'($signed(in_tdata[30:0])),
                                     longint'($signed(in_tdata[62:31])),
                                     longint'($signed(in_tdata[87:63])));
        dist_q.push_back(held_cm);
      end
      if (out_tvalid && out_tready) begin
        if (dist_q.size() == 0) begin
          $error("distance_cm: no result expected, got %0d", out_tdata[30:0]);
          errs++;
        end else begin
          want = dist_q.pop_front();
          if (out_tdata[30:0] !== want) begin
            $error("distance_cm: expected %0d, got %0d", want, out_tdata[30:0]);
            errs++;
          end
          if (out_tdata[31] !== 1'b0) begin
            $error("pad bit: expected 0, got %b", out_tdata[31]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import hdh_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int PHASE_ITEMS = 430;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          tx_idle_pct = 24;
  int          rx_idle_pct = 57;
  longint      cur_lat, cur_lon, cur_alt;

  always #1 clk = ~clk;

  haversine_distance_to_home u_top (.*);

  hdh_distance_checker u_chk (.*);

  always @(negedge clk) out_tready <= ($urandom_range(99) >= rx_idle_pct);

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  task automatic send_fix(longint lat, longint lon, longint alt, bit fix);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {alt[24:0], lon[31:0], lat[30:0]};
    in_tuser = fix;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_home(longint lat, longint lon, longint alt);
    drain();
    write_reg(REG_HOME_LAT, 32'(lat));
    write_reg(REG_HOME_LON, 32'(lon));
    write_reg(REG_HOME_ALT, 32'(alt));
    write_reg(REG_SPARE, $urandom);
    cur_lat = lat;
    cur_lon = lon;
    cur_alt = alt;
  endtask

  task automatic random_fix();
    int kind;
    longint lat, lon, alt;
    kind = $urandom_range(99);
    lat = longint'($urandom_range(1800000000)) - 900000000;
    lon = longint'($urandom_range(32'd3600000000)) - 1800000000;
    alt = longint'($urandom_range(10100000)) - 100000;
    if (kind < 20) begin
      // stay close to home for short distances
      lat = cur_lat + longint'($urandom_range(20000)) - 10000;
      lon = cur_lon + longint'($urandom_range(20000)) - 10000;
      alt = cur_alt + longint'($urandom_range(2000)) - 1000;
      if (lat > 900000000 || lat < -900000000) lat = cur_lat;
      if (lon > 1800000000 || lon < -1800000000) lon = cur_lon;
      if (alt > 10000000 || alt < -100000) alt = cur_alt;
    end else if (kind < 30) begin
      lat = longint'($signed(31'($urandom)));
      lon = longint'($signed($urandom));
      alt = longint'($signed(25'($urandom)));
    end
    send_fix(lat, lon, alt, kind >= 88 ? 1'b0 : 1'b1);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // held distance starts at zero
    send_fix(123456789, -987654321, 5000, 0);
    send_fix(0, 0, 0, 1);
    send_fix(900000000, 0, 0, 1);
    send_fix(-900000000, 0, 0, 1);
    send_fix(0, 1800000000, 0, 1);
    send_fix(0, -1800000000, 10000000, 1);
    send_fix(0, 0, -100000, 1);
    send_fix(1073741823, 2147483647, 16777215, 1);
    send_fix(-1073741824, -2147483648, -16777216, 1);
    send_fix(0, 0, 0, 0);
    send_fix(450000000, 900000000, 2500000, 1);

    set_home(-900000000, 1800000000, 10000000);
    send_fix(900000000, -1800000000, -100000, 1);
    send_fix(-900000000, -1800000000, 10000000, 1);
    send_fix(0, -1800000000, 10000000, 1);
    send_fix(-899999999, 1799999999, 10000000, 1);
    send_fix(1073741823, -2147483648, 0, 1);
    send_fix(0, 0, 0, 0);

    set_home(900000000, -1800000000, -100000);
    send_fix(-900000000, 1800000000, 10000000, 1);
    send_fix(900000000, 1800000000, -100000, 1);
    send_fix(-1073741824, 2147483647, 16777215, 1);
    send_fix(900000000, -1800000000, -100000, 1);

    set_home(0, 0, 0);
    for (int i = 0; i < PHASE_ITEMS; i++) random_fix();

    tx_idle_pct = 57;
    rx_idle_pct = 24;
    set_home(longint'($urandom_range(1800000000)) - 900000000,
             longint'($urandom_range(32'd3600000000)) - 1800000000,
             longint'($urandom_range(10100000)) - 100000);
    for (int i = 0; i < PHASE_ITEMS; i++) random_fix();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_home(-423456789, 1512345678, 250000);
    for (int i = 0; i < PHASE_ITEMS; i++) random_fix();

    drain();
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      if (pending != 0) $error("distance_cm: %0d results never arrived", pending);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
